### hw/rtl/first_fit_block_allocator_core_assert.svh
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/ffba_pkg.sv
package ffba_pkg;
  localparam int unsigned HEAP_BYTES   = 8 * 1024 * 1024;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned OFF_W  = 23;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned NEED_W = 25;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RDF, S_A_RDB, S_A_CHK, S_SH_RD, S_SH_WR,
    S_A_UPD, S_A_SPLIT, S_F_RD, S_F_CHK, S_DONE
  } state_t;

  // Round up to the alignment, one bit wider to hold the carry.
  function automatic logic [NEED_W-1:0] round_to_align(input logic [SIZE_W-1:0] req);
    logic [NEED_W-1:0] s;
    s = {1'b0, req} + NEED_W'(ALIGN_BYTES - 1);
    return s & ~NEED_W'(ALIGN_BYTES - 1);
  endfunction
endpackage

### hw/rtl/first_fit_block_allocator_core.sv
// Allocate scans the free list (read entry, read block, check); on a fit it shifts the
// later entries down, marks the block used, splits off any rest and shows the result;
// free scans the block table; a null free or an empty free list goes straight to done.
// Throughput: one item at a time; busy stays high through done.
// Reset: synchronous; the first cycle after reset writes the initial heap block, then idle.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
`include "first_fit_block_allocator_core_assert.svh"
module first_fit_block_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [23:0] request_bytes,
  input  logic [22:0] free_address,
  output logic        done,
  output logic [22:0] payload_offset,
  output logic [1:0]  status
);
  localparam int unsigned IW = ffba_pkg::IDX_W;
  localparam int unsigned CW = ffba_pkg::CNT_W;
  localparam int unsigned OW = ffba_pkg::OFF_W;
  localparam int unsigned SW = ffba_pkg::SIZE_W;
  localparam int unsigned NW = ffba_pkg::NEED_W;
  localparam int unsigned BW = 1 + SW + OW;

  // Block entry: {used, size, offset}.
  logic [BW-1:0] blk_mem [ffba_pkg::MAX_BLOCKS];
  logic [IW-1:0] fo_mem  [ffba_pkg::MAX_BLOCKS];

  ffba_pkg::state_t state, state_next;
  logic [CW-1:0] idx, fcnt, bcnt;
  logic [IW-1:0] blk;
  logic [NW-1:0] size, need;
  logic [SW-1:0] rest;
  logic [OW-1:0] boff, addr;
  logic [OW-1:0] res_off;
  ffba_pkg::status_t res_st;

  logic [BW-1:0] bk_rd;
  logic [OW-1:0] of_rd;
  logic [SW-1:0] sz_rd;
  logic          used_rd;
  logic [IW-1:0] fo_rd;
  logic [IW-1:0] ra_fo, ra_bk, wa_fo, wa_bk;
  logic we_fo, we_bk;
  logic [IW-1:0] wd_fo;
  logic [BW-1:0] wd_bk;

  logic          fit, hit_free, free_ok;
  logic [SW-1:0] diff;
  logic [OW:0]   pay_sum;

  assign of_rd    = bk_rd[OW-1:0];
  assign sz_rd    = bk_rd[OW+SW-1:OW];
  assign used_rd  = bk_rd[BW-1];
  assign diff     = SW'(({1'b0, sz_rd}) - need);
  assign fit      = ({1'b0, sz_rd} >= need);
  assign pay_sum  = {1'b0, of_rd} + (OW+1)'(ffba_pkg::HEADER_BYTES);
  assign hit_free = (pay_sum == {1'b0, addr});
  assign free_ok  = hit_free && used_rd && (fcnt != CW'(ffba_pkg::MAX_BLOCKS));

  always_ff @(posedge clk) begin
    if (we_fo) fo_mem[wa_fo] <= wd_fo;
    if (we_bk) blk_mem[wa_bk] <= wd_bk;
    fo_rd <= fo_mem[ra_fo];
    bk_rd <= blk_mem[ra_bk];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ffba_pkg::S_INIT: state_next = ffba_pkg::S_IDLE;
      ffba_pkg::S_IDLE: begin
        if (start) begin
          if (!command) state_next = (fcnt == '0) ? ffba_pkg::S_DONE : ffba_pkg::S_A_RDF;
          else if (free_address == '0) state_next = ffba_pkg::S_DONE;
          else state_next = ffba_pkg::S_F_RD;
        end
      end
      ffba_pkg::S_A_RDF: state_next = ffba_pkg::S_A_RDB;
      ffba_pkg::S_A_RDB: state_next = ffba_pkg::S_A_CHK;
      ffba_pkg::S_A_CHK: begin
        if (fit) begin
          if (diff != '0 && bcnt == CW'(ffba_pkg::MAX_BLOCKS)) state_next = ffba_pkg::S_DONE;
          else if (idx + 1'b1 < fcnt) state_next = ffba_pkg::S_SH_RD;
          else state_next = ffba_pkg::S_A_UPD;
        end else if (idx + 1'b1 < fcnt) state_next = ffba_pkg::S_A_RDF;
        else state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_SH_RD: state_next = ffba_pkg::S_SH_WR;
      ffba_pkg::S_SH_WR: state_next = (idx + 2'd2 < fcnt) ? ffba_pkg::S_SH_RD
                                                          : ffba_pkg::S_A_UPD;
      ffba_pkg::S_A_UPD: state_next = (rest != '0) ? ffba_pkg::S_A_SPLIT : ffba_pkg::S_DONE;
      ffba_pkg::S_A_SPLIT: state_next = ffba_pkg::S_DONE;
      ffba_pkg::S_F_RD: state_next = ffba_pkg::S_F_CHK;
      ffba_pkg::S_F_CHK: begin
        if (hit_free || idx + 1'b1 >= bcnt) state_next = ffba_pkg::S_DONE;
        else state_next = ffba_pkg::S_F_RD;
      end
      ffba_pkg::S_DONE: state_next = ffba_pkg::S_IDLE;
      default: state_next = ffba_pkg::S_INIT;
    endcase
  end

  // Memory control and outputs.
  always_comb begin
    ra_fo = idx[IW-1:0];
    ra_bk = idx[IW-1:0];
    wa_fo = fcnt[IW-1:0];
    wa_bk = blk;
    we_fo = 1'b0;
    we_bk = 1'b0;
    wd_fo = idx[IW-1:0];
    wd_bk = '0;
    case (state)
      ffba_pkg::S_INIT: begin
        we_fo = 1'b1; we_bk = 1'b1;
        wa_fo = '0; wa_bk = '0; wd_fo = '0;
        wd_bk = {1'b0, SW'(ffba_pkg::HEAP_BYTES), {OW{1'b0}}};
      end
      ffba_pkg::S_A_RDB: ra_bk = fo_rd;
      ffba_pkg::S_SH_RD: ra_fo = IW'(idx + 1'b1);
      ffba_pkg::S_SH_WR: begin
        we_fo = 1'b1; wa_fo = idx[IW-1:0]; wd_fo = fo_rd;
      end
      ffba_pkg::S_A_UPD: begin
        we_bk = 1'b1;
        wd_bk = {1'b1, size[SW-1:0], boff};
      end
      ffba_pkg::S_A_SPLIT: begin
        we_fo = 1'b1; we_bk = 1'b1;
        wa_bk = bcnt[IW-1:0];
        wd_fo = bcnt[IW-1:0];
        wd_bk = {1'b0, rest, OW'({2'b0, boff} + need)};
      end
      ffba_pkg::S_F_CHK: begin
        we_fo = free_ok;
        we_bk = free_ok;
        wa_bk = idx[IW-1:0];
        wd_bk = {1'b0, sz_rd, of_rd};
      end
      default: ;
    endcase
    busy           = (state != ffba_pkg::S_IDLE);
    done           = (state == ffba_pkg::S_DONE);
    payload_offset = res_off;
    status         = res_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_INIT;
      fcnt  <= CW'(1);
      bcnt  <= CW'(1);
    end else begin
      state <= state_next;
      case (state)
        ffba_pkg::S_IDLE: begin
          idx     <= '0;
          size    <= ffba_pkg::round_to_align(request_bytes);
          need    <= ffba_pkg::round_to_align(request_bytes) + NW'(ffba_pkg::HEADER_BYTES);
          addr    <= free_address;
          res_off <= '0;
          res_st  <= command ? ffba_pkg::ST_OK : ffba_pkg::ST_NOMEM;
        end
        ffba_pkg::S_A_RDB: blk <= fo_rd;
        ffba_pkg::S_A_CHK: begin
          if (fit) begin
            rest <= diff;
            boff <= of_rd;
            if (diff != '0 && bcnt == CW'(ffba_pkg::MAX_BLOCKS)) res_st <= ffba_pkg::ST_FULL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ffba_pkg::S_SH_WR: idx <= idx + 1'b1;
        ffba_pkg::S_A_UPD: begin
          fcnt      <= fcnt - 1'b1;
          res_st    <= ffba_pkg::ST_OK;
          res_off   <= OW'({1'b0, boff} + (OW+1)'(ffba_pkg::HEADER_BYTES));
        end
        ffba_pkg::S_A_SPLIT: begin
          fcnt <= fcnt + 1'b1;
          bcnt <= bcnt + 1'b1;
        end
        ffba_pkg::S_F_CHK: begin
          if (hit_free) begin
            if (free_ok) begin
              fcnt   <= fcnt + 1'b1;
              res_st <= ffba_pkg::ST_OK;
            end else begin
              res_st <= ffba_pkg::ST_BADFREE;
            end
          end else begin
            idx    <= idx + 1'b1;
            res_st <= ffba_pkg::ST_BADFREE;
          end
        end
        default: ;
      endcase
    end
  end

  `FFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `FFBA_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `FFBA_ASSERT_NOW(a_fcnt_range, 1'b1, fcnt <= CW'(ffba_pkg::MAX_BLOCKS), "free count overflow")
  `FFBA_ASSERT_NOW(a_bcnt_range, 1'b1, bcnt <= CW'(ffba_pkg::MAX_BLOCKS) && bcnt != '0,
                   "block count out of range")
endmodule
